### rtl/ptca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptca_pkg
// Shared widths, command codes, divider constants and types of the prescaled
// timer with compare alarms.
// ----------------------------------------------------------------------------
package ptca_pkg;

	localparam int PRESCALE_W = 3;
	localparam int PRESCALE_N = 8;
	localparam int CMD_W      = 2;
	localparam int US_W       = 32;
	localparam int CNT_W      = 16;
	localparam int PCNT_W     = 7;
	localparam int TICKS_W    = 32;
	localparam int MULT_W     = 14;
	localparam int Q_W        = 19;
	localparam int ELAPSED_W  = 32;

	localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ARM_ONCE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ARM_EVERY = 2'd2;

	localparam int unsigned US_HZ = 1000000;

	// x / 10000 for 32-bit x: q0 = (x * DIV_MAGIC) >> DIV_SHIFT is low by at most one
	localparam logic [MULT_W-1:0]  DIV_CONST = 14'd10000;
	localparam logic [TICKS_W-1:0] DIV_MAGIC = 32'd3518437208;
	localparam int                 DIV_SHIFT = 45;

	localparam logic [PRESCALE_W-1:0] ELAPSED_BIAS = 3'd3;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [TICKS_W-1:0] ticks;
	} ptca_tick_t;

endpackage
`default_nettype wire

### rtl/ptca_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptca channel interfaces
// Valid/ready channels for configuration, input items and results.
// ----------------------------------------------------------------------------
interface ptca_cfg_if import ptca_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [PRESCALE_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ptca_item_if import ptca_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [US_W-1:0]  delay_us;

	modport source (output valid, output cmd, output delay_us, input ready);
	modport sink (input valid, input cmd, input delay_us, output ready);
endinterface

interface ptca_result_if import ptca_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [ELAPSED_W-1:0] elapsed_us;
	logic                 once_fired;
	logic                 every_fired;

	modport source (output valid, output elapsed_us, output once_fired, output every_fired,
		input ready);
	modport sink (input valid, input elapsed_us, input once_fired, input every_fired,
		output ready);
endinterface
`default_nettype wire

### rtl/prescaled_timer_with_compare_alarms.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prescaled_timer_with_compare_alarms
// Prescaled 16-bit timer with one-shot and periodic compare alarms.
//
//   channel | modport | payload                               | per transaction
//   cfg     | sink    | data (prescale, 3 bits)               | prescale write
//   item    | sink    | cmd (2), delay_us (32)                | tick or arm
//   result  | source  | elapsed_us (32), once_fired, every_fired | one per item
//
// One item per cycle while results are taken; a result is offered once its item has
// passed four delay-conversion stages, the tick register and the result register.
// Reset clears the counter, prescaler, alarms and prescale; no clearing pass.
// Backpressure ripples stage by stage, so item.ready stays high while any
// stage is empty, even when the result waits.
// ----------------------------------------------------------------------------
module prescaled_timer_with_compare_alarms import ptca_pkg::*; #(
	parameter int unsigned E_CLOCK_HZ = 8000000
) (
	input  logic          clk,
	input  logic          arst_n,
	ptca_cfg_if.sink      cfg,
	ptca_item_if.sink     item,
	ptca_result_if.source result
);

	logic [PRESCALE_W-1:0] prescale_q;
	logic                  tick_valid, tick_ready;
	ptca_tick_t            tick;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
		end else if (cfg.valid) begin
			prescale_q <= cfg.data;
		end
	end

	ptca_conv #(
		.E_CLOCK_HZ (E_CLOCK_HZ)
	) u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.prescale   (prescale_q),
		.in_valid   (item.valid),
		.in_cmd     (item.cmd),
		.in_us      (item.delay_us),
		.in_ready   (item.ready),
		.tick_valid (tick_valid),
		.tick       (tick),
		.tick_ready (tick_ready)
	);

	ptca_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.prescale    (prescale_q),
		.tick_valid  (tick_valid),
		.tick        (tick),
		.tick_ready  (tick_ready),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.elapsed_us  (result.elapsed_us),
		.once_fired  (result.once_fired),
		.every_fired (result.every_fired)
	);

endmodule
`default_nettype wire

### rtl/ptca_conv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptca_conv
// Five-stage pipeline turning a delay in microseconds into counter ticks.
// Every item passes through so the order to the timer core is kept.
// ----------------------------------------------------------------------------
module ptca_conv import ptca_pkg::*; #(
	parameter int unsigned E_CLOCK_HZ = 8000000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [PRESCALE_W-1:0] prescale,
	input  logic                  in_valid,
	input  logic [CMD_W-1:0]      in_cmd,
	input  logic [US_W-1:0]       in_us,
	output logic                  in_ready,
	output logic                  tick_valid,
	output ptca_tick_t            tick,
	input  logic                  tick_ready
);

	logic [MULT_W-1:0]     mult_tab [PRESCALE_N];
	logic [PRESCALE_N-1:0] div_tab;

	for (genvar g = 0; g < PRESCALE_N; g++) begin : g_rate
		localparam int unsigned F_HZ    = E_CLOCK_HZ >> g;
		localparam int unsigned PER_US  = F_HZ / US_HZ;
		localparam int unsigned F_CENTI = F_HZ / 100;
		assign mult_tab[g] = (PER_US != 0) ? MULT_W'(PER_US) : MULT_W'(F_CENTI);
		assign div_tab[g]  = (PER_US == 0);
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	logic [CMD_W-1:0]   cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5;
	logic [US_W-1:0]    us_s1;
	logic [TICKS_W-1:0] x_s2, x_s3, x_s4, ticks_s5;
	logic               div_s2, div_s3, div_s4;
	logic [Q_W-1:0]     q0_s3, q0_s4;
	logic [TICKS_W-1:0] qm_s4;

	logic [US_W+MULT_W-1:0] prod_a;
	logic [2*TICKS_W-1:0]   prod_b;
	logic [Q_W+MULT_W-1:0]  prod_c;
	logic [TICKS_W-1:0]     rem;
	logic [Q_W-1:0]         q_fix;

	// bubbles collapse: a stage loads when it is empty or its successor moves
	assign en_s5    = !v_s5 || tick_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_comb begin
		prod_a = (US_W+MULT_W)'(us_s1) * (US_W+MULT_W)'(mult_tab[prescale]);
		prod_b = (2*TICKS_W)'(x_s2) * (2*TICKS_W)'(DIV_MAGIC);
		prod_c = (Q_W+MULT_W)'(q0_s3) * (Q_W+MULT_W)'(DIV_CONST);
		rem    = x_s4 - qm_s4;
		q_fix  = (rem >= TICKS_W'(DIV_CONST)) ? q0_s4 + Q_W'(1) : q0_s4;
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cmd_s1 <= in_cmd;
			us_s1  <= in_us;
		end
		if (en_s2) begin
			cmd_s2 <= cmd_s1;
			x_s2   <= prod_a[TICKS_W-1:0];
			div_s2 <= div_tab[prescale];
		end
		if (en_s3) begin
			cmd_s3 <= cmd_s2;
			x_s3   <= x_s2;
			div_s3 <= div_s2;
			q0_s3  <= prod_b[DIV_SHIFT+Q_W-1:DIV_SHIFT];
		end
		if (en_s4) begin
			cmd_s4 <= cmd_s3;
			x_s4   <= x_s3;
			div_s4 <= div_s3;
			q0_s4  <= q0_s3;
			qm_s4  <= prod_c[TICKS_W-1:0];
		end
		if (en_s5) begin
			cmd_s5   <= cmd_s4;
			ticks_s5 <= div_s4 ? TICKS_W'(q_fix) : x_s4;
		end
	end

	assign tick_valid = v_s5;
	assign tick.cmd   = cmd_s5;
	assign tick.ticks = ticks_s5;

endmodule
`default_nettype wire

### rtl/ptca_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptca_core
// Prescaler, 16-bit counter with wrap count, one-shot and periodic compare
// alarms, and the result register.
// ----------------------------------------------------------------------------
module ptca_core import ptca_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [PRESCALE_W-1:0] prescale,
	input  logic                  tick_valid,
	input  ptca_tick_t            tick,
	output logic                  tick_ready,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [ELAPSED_W-1:0]  elapsed_us,
	output logic                  once_fired,
	output logic                  every_fired
);

	logic [PCNT_W-1:0] pcnt_q;
	logic [CNT_W-1:0]  tc_q, wc_q;
	logic              once_armed_q, every_armed_q;
	logic [CNT_W-1:0]  once_match_q, once_wl_q;
	logic [CNT_W-1:0]  every_match_q, every_step_q, every_wl_q, every_reload_q;
	logic              res_valid_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic              once_q, every_q;

	logic              fire;
	logic              is_tick, adv;
	logic [PCNT_W-1:0] pc_inc;
	logic [PCNT_W:0]   limit;
	logic [PCNT_W-1:0] pcnt_n;
	logic [CNT_W-1:0]  tc_n, wc_n;
	logic [CNT_W-1:0]  hi, lo;
	logic              once_armed_n, every_armed_n;
	logic [CNT_W-1:0]  once_match_n, once_wl_n;
	logic [CNT_W-1:0]  every_match_n, every_step_n, every_wl_n, every_reload_n;
	logic              once_f, every_f;
	logic [2*CNT_W-1:0] n_cnt;
	logic [ELAPSED_W-1:0] elapsed_n;

	assign tick_ready = !res_valid_q || res_ready;
	assign fire       = tick_valid && tick_ready;

	always_comb begin
		is_tick = (tick.cmd == CMD_TICK);
		pc_inc  = pcnt_q + PCNT_W'(1);
		limit   = {{PCNT_W{1'b0}}, 1'b1} << prescale;
		adv     = is_tick && ({1'b0, pc_inc} >= limit);
		pcnt_n  = is_tick ? (adv ? '0 : pc_inc) : pcnt_q;
		tc_n    = adv ? tc_q + CNT_W'(1) : tc_q;
		wc_n    = (adv && tc_n == '0) ? wc_q + CNT_W'(1) : wc_q;

		hi = tick.ticks[TICKS_W-1:CNT_W];
		lo = tick.ticks[CNT_W-1:0];
		if (hi == '0 && lo == '0) lo = CNT_W'(1);

		once_armed_n   = once_armed_q;
		once_match_n   = once_match_q;
		once_wl_n      = once_wl_q;
		every_armed_n  = every_armed_q;
		every_match_n  = every_match_q;
		every_step_n   = every_step_q;
		every_wl_n     = every_wl_q;
		every_reload_n = every_reload_q;
		once_f         = 1'b0;
		every_f        = 1'b0;

		// compare only on a counter advance, against the new count
		if (adv && once_armed_q && tc_n == once_match_q) begin
			if (once_wl_q == '0) begin
				once_f       = 1'b1;
				once_armed_n = 1'b0;
			end else begin
				once_wl_n = once_wl_q - CNT_W'(1);
			end
		end
		if (adv && every_armed_q && tc_n == every_match_q) begin
			if (every_wl_q == '0) begin
				every_f       = 1'b1;
				every_wl_n    = every_reload_q;
				every_match_n = every_match_q + every_step_q;
			end else begin
				every_wl_n = every_wl_q - CNT_W'(1);
			end
		end

		case (tick.cmd)
			CMD_ARM_ONCE: begin
				once_wl_n    = hi;
				once_match_n = tc_q + lo;
				once_armed_n = 1'b1;
			end
			CMD_ARM_EVERY: begin
				every_wl_n     = hi;
				every_reload_n = hi;
				every_step_n   = lo;
				every_match_n  = tc_q + lo;
				every_armed_n  = 1'b1;
			end
			default: begin
			end
		endcase

		n_cnt = {wc_n, tc_n};
		if (prescale < ELAPSED_BIAS)
			elapsed_n = n_cnt >> (ELAPSED_BIAS - prescale);
		else
			elapsed_n = n_cnt << (prescale - ELAPSED_BIAS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q         <= '0;
			tc_q           <= '0;
			wc_q           <= '0;
			once_armed_q   <= 1'b0;
			once_match_q   <= '0;
			once_wl_q      <= '0;
			every_armed_q  <= 1'b0;
			every_match_q  <= '0;
			every_step_q   <= '0;
			every_wl_q     <= '0;
			every_reload_q <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			if (fire) begin
				pcnt_q         <= pcnt_n;
				tc_q           <= tc_n;
				wc_q           <= wc_n;
				once_armed_q   <= once_armed_n;
				once_match_q   <= once_match_n;
				once_wl_q      <= once_wl_n;
				every_armed_q  <= every_armed_n;
				every_match_q  <= every_match_n;
				every_step_q   <= every_step_n;
				every_wl_q     <= every_wl_n;
				every_reload_q <= every_reload_n;
				res_valid_q    <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			elapsed_q <= elapsed_n;
			once_q    <= once_f;
			every_q   <= every_f;
		end
	end

	assign res_valid   = res_valid_q;
	assign elapsed_us  = elapsed_q;
	assign once_fired  = once_q;
	assign every_fired = every_q;

endmodule
`default_nettype wire

### rtl/ptca_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptca_chk
// Port-level checks of the prescaled timer, bound to the top level.
// ----------------------------------------------------------------------------
module ptca_chk import ptca_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 item_valid,
	input wire logic                 item_ready,
	input wire logic                 result_valid,
	input wire logic                 result_ready,
	input wire logic [ELAPSED_W-1:0] result_elapsed_us,
	input wire logic                 result_once_fired
);

	logic [2:0] inflight_q;
	logic       prev_once_q;
	logic       item_xact, result_xact;

	assign item_xact   = item_valid && item_ready;
	assign result_xact = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q  <= '0;
			prev_once_q <= 1'b0;
		end else begin
			inflight_q <= inflight_q + 3'(item_xact) - 3'(result_xact);
			if (result_xact) prev_once_q <= result_once_fired;
		end
	end

	// with nothing waiting at the output the pipeline must take items
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("item not accepted while no result is pending");

	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> inflight_q != 3'd0)
		else $error("result offered with no item in flight");

	// an arm transaction (flags low) must separate two one-shot expiries
	a_once_not_twice: assert property (@(posedge clk) disable iff (!arst_n)
		result_xact && result_once_fired |-> !prev_once_q)
		else $error("one-shot alarm fired on two results in a row");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_elapsed_us))
		else $error("stalled result dropped or changed");

endmodule

bind prescaled_timer_with_compare_alarms ptca_chk u_ptca_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.result_elapsed_us (result.elapsed_us),
	.result_once_fired (result.once_fired)
);
`default_nettype wire
